### design/hpci_pkg.sv
// shared constants, types and the cosine table for the hue projection intensity core
`timescale 1ns / 1ps

package hpci_pkg;

  // pixel and angle widths
  localparam int PIX_W = 8;
  localparam int ANG_W = 9;
  localparam int SUM_W = ANG_W + 1;

  // angle constants in whole degrees
  localparam logic [ANG_W-1:0] DEG_FULL    = ANG_W'(360);
  localparam logic [ANG_W-1:0] DEG_QUARTER = ANG_W'(90);
  localparam logic [ANG_W-1:0] DEG_3QUART  = ANG_W'(270);
  localparam logic [SUM_W-1:0] DEG_TWO_REV = SUM_W'(720);

  // cosine table geometry
  localparam int COS_FRAC_BITS = 14;
  localparam int COS_W         = COS_FRAC_BITS + 1;
  localparam int IDX_W         = $clog2(90 + 1);
  localparam int TBL_DEPTH     = 2 ** IDX_W;
  localparam logic [IDX_W-1:0] IDX_ZERO = IDX_W'(90);

  // product and divide-by-255 stage
  localparam int SV_W   = 2 * PIX_W;
  localparam int PROD_W = COS_W + SV_W;
  localparam int RND_W  = PROD_W + 1;
  localparam int QUO_W  = 16;
  localparam int MUL_W  = 2 * QUO_W;
  localparam logic [RND_W-1:0] RND_HALF  = RND_W'(255) << (COS_FRAC_BITS - 1);
  localparam logic [QUO_W-1:0] DIV255_K  = 16'h8081;
  localparam int               DIV255_SH = 23;

  typedef logic [TBL_DEPTH-1:0][COS_W-1:0] cos_tbl_t;

  // q60 fixed-point helpers, only used while building the table
  localparam logic [63:0] Q60_ONE   = 64'd1 << 60;
  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_DEG_Q  = PI_Q60 / 64'd180;
  localparam logic [63:0] PI_DEG_R  = PI_Q60 % 64'd180;
  localparam logic [63:0] DEG_DIV   = 64'd180;
  localparam int          N_TERMS   = 40;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // unsigned quotient by shift and subtract, divisor below 2^63
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos(d deg) for d in 0..89, rounded half up to COS_FRAC_BITS fraction bits
  function automatic cos_tbl_t cos_tbl_build();
    cos_tbl_t    tbl;
    logic [63:0] dd;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] div;
    logic [63:0] ent;
    tbl = '0;
    for (int d = 0; d < 90; d++) begin
      dd   = 64'(d);
      x    = dd * PI_DEG_Q + udiv64(dd * PI_DEG_R, DEG_DIV);
      x2   = mul_q60(x, x);
      term = Q60_ONE;
      sum  = Q60_ONE;
      for (int n = 1; n < N_TERMS; n++) begin
        div  = 64'((2 * n - 1) * (2 * n));
        term = udiv64(mul_q60(term, x2), div);
        if ((n & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum[63]) begin
        sum = '0;
      end
      ent    = (sum + (64'd1 << (59 - COS_FRAC_BITS))) >> (60 - COS_FRAC_BITS);
      tbl[d] = ent[COS_W-1:0];
    end
    return tbl;
  endfunction

  localparam cos_tbl_t COS_TBL = cos_tbl_build();

endpackage

### design/hue_projected_color_intensity_core.sv
// top level of the hue projection intensity core: four-stage pixel pipeline
`timescale 1ns / 1ps

// Hue projection intensity core. Each input word is one HSV pixel (hue in
// 2-degree units, 8-bit saturation and value); each output word is the 8-bit
// intensity round(max(0, cos(2*hue - orient) * S/255 * V/255) * 255), rounded
// half up, negative projections clamped to zero. The angle wraps modulo 360,
// so hue codes above 179 and orient values above 359 are legal. Orient is
// written through the cfg port in whole degrees (reset 0, red); cfg_ready is
// always high, and a write should only happen while no pixel is in flight.
// Throughput is one pixel per clock while the output is not stalled. There
// are four register stages: angle reduction, cosine table and S*V product,
// cosine times S*V, rounding and divide by 255. A pixel passes through them
// in that order before out_valid rises. Each stage has its own valid bit and
// loads whenever it is empty or the stage after it can move, so a stall at
// the output only backs up as far as the pipeline is full.
module hue_projected_color_intensity_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hpci_pkg::ANG_W-1:0] cfg_hue_orient,
  // pixel input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hpci_pkg::PIX_W-1:0] in_hue,
  input  logic [hpci_pkg::PIX_W-1:0] in_saturation,
  input  logic [hpci_pkg::PIX_W-1:0] in_brightness,
  // intensity output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hpci_pkg::PIX_W-1:0] out_intensity
);

  // ------------------------------------------------------------------
  // configuration: keep 360 - (orient mod 360) so stage 1 only adds
  // ------------------------------------------------------------------
  logic [hpci_pkg::ANG_W-1:0] ofs_r, ofs_nxt;
  logic [hpci_pkg::ANG_W-1:0] orient_red;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_hue_orient >= hpci_pkg::DEG_FULL) begin
      orient_red = cfg_hue_orient - hpci_pkg::DEG_FULL;
    end else begin
      orient_red = cfg_hue_orient;
    end
    ofs_nxt = hpci_pkg::DEG_FULL - orient_red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r <= hpci_pkg::DEG_FULL;
    end else if (cfg_valid && cfg_ready) begin
      ofs_r <= ofs_nxt;
    end
  end

  // ------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or drains
  // ------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  // ------------------------------------------------------------------
  // stage 1: angle d = (2*hue + 360 - orient) mod 360
  // sum lies in 1..870, so at most one subtract of 360 or 720
  // ------------------------------------------------------------------
  logic [hpci_pkg::SUM_W-1:0] ang_sum;
  logic [hpci_pkg::SUM_W-1:0] ang_mod;
  logic [hpci_pkg::ANG_W-1:0] ang_r, ang_nxt;
  logic [hpci_pkg::PIX_W-1:0] sat1_r, val1_r;

  always_comb begin
    ang_sum = {1'b0, in_hue, 1'b0} + hpci_pkg::SUM_W'(ofs_r);
    if (ang_sum >= hpci_pkg::DEG_TWO_REV) begin
      ang_mod = ang_sum - hpci_pkg::DEG_TWO_REV;
    end else if (ang_sum >= hpci_pkg::SUM_W'(hpci_pkg::DEG_FULL)) begin
      ang_mod = ang_sum - hpci_pkg::SUM_W'(hpci_pkg::DEG_FULL);
    end else begin
      ang_mod = ang_sum;
    end
    ang_nxt = ang_mod[hpci_pkg::ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ang_r  <= ang_nxt;
      sat1_r <= in_saturation;
      val1_r <= in_brightness;
    end
  end

  // ------------------------------------------------------------------
  // stage 2: fold angle into the first quadrant, read the table;
  // 90..270 degrees points at the zero entry, which is the clamp
  // ------------------------------------------------------------------
  logic [hpci_pkg::ANG_W-1:0] mirror;
  logic [hpci_pkg::IDX_W-1:0] tbl_idx;
  logic [hpci_pkg::COS_W-1:0] cos_r, cos_nxt;
  logic [hpci_pkg::SV_W-1:0]  sv_r, sv_nxt;

  always_comb begin
    mirror = hpci_pkg::DEG_FULL - ang_r;
    if (ang_r < hpci_pkg::DEG_QUARTER) begin
      tbl_idx = ang_r[hpci_pkg::IDX_W-1:0];
    end else if (ang_r > hpci_pkg::DEG_3QUART) begin
      tbl_idx = mirror[hpci_pkg::IDX_W-1:0];
    end else begin
      tbl_idx = hpci_pkg::IDX_ZERO;
    end
    cos_nxt = hpci_pkg::COS_TBL[tbl_idx];
    sv_nxt  = hpci_pkg::SV_W'(sat1_r) * hpci_pkg::SV_W'(val1_r);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      cos_r <= cos_nxt;
      sv_r  <= sv_nxt;
    end
  end

  // ------------------------------------------------------------------
  // stage 3: cos * S * V
  // ------------------------------------------------------------------
  logic [hpci_pkg::PROD_W-1:0] prod_r, prod_nxt;

  assign prod_nxt = hpci_pkg::PROD_W'(cos_r) * hpci_pkg::PROD_W'(sv_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      prod_r <= prod_nxt;
    end
  end

  // ------------------------------------------------------------------
  // stage 4: round half up and divide by 255 * 2^F
  // the shift by F is exact after adding the half; the remaining
  // quotient is below 65536, where x * 0x8081 >> 23 equals x / 255
  // ------------------------------------------------------------------
  logic [hpci_pkg::RND_W-1:0] rnd;
  logic [hpci_pkg::QUO_W-1:0] quo;
  logic [hpci_pkg::MUL_W-1:0] div_prod;
  logic [hpci_pkg::PIX_W-1:0] int_r, int_nxt;

  always_comb begin
    rnd      = hpci_pkg::RND_W'(prod_r) + hpci_pkg::RND_HALF;
    quo      = rnd[hpci_pkg::COS_FRAC_BITS +: hpci_pkg::QUO_W];
    div_prod = hpci_pkg::MUL_W'(quo) * hpci_pkg::MUL_W'(hpci_pkg::DIV255_K);
    int_nxt  = div_prod[hpci_pkg::DIV255_SH +: hpci_pkg::PIX_W];
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      int_r <= int_nxt;
    end
  end

  assign out_valid     = v4_r;
  assign out_intensity = int_r;

`ifndef ASSERT_OFF
  // stored offset always stands for an orient in 0..359
  a_ofs_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ofs_r >= 9'd1) && (ofs_r <= hpci_pkg::DEG_FULL))
    else $error("orient offset out of range");

  // reduced angle is a valid degree whenever stage 1 holds a pixel
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (ang_r < hpci_pkg::DEG_FULL))
    else $error("stage 1 angle not reduced below 360");

  // angles facing away from the orient must give a zero cosine
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    rdy2 && v1_r && (ang_r >= hpci_pkg::DEG_QUARTER) && (ang_r <= hpci_pkg::DEG_3QUART)
    |=> (cos_r == '0))
    else $error("cosine not clamped for back-facing angle");

  // an accepted pixel always lands in stage 1
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted pixel lost at stage 1");

  // a stalled output holds and no newer word overtakes it
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_ready |=> v4_r && $stable(int_r))
    else $error("stalled output word changed");
`endif

endmodule
